@@ design/tet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event table package
// Shared widths, command codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int unsigned TET_CAPACITY    = 32;
  localparam int unsigned TET_HANDLE_BITS = 16;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned OCC_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_TAKE       = 3'd2,
    CMD_SET_TIME   = 3'd3,
    CMD_MARK_DIRTY = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_rd;
    logic resolve;
    logic shift_rd;
    logic shift_end;
    logic ld_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_scan_cmd;
    logic need_scan;
    logic scan_last;
    logic hit;
    logic shift_all_issued;
    logic shift_busy;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/tet_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event table channels
// Command channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface tet_in_if;
  import tet_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [HANDLE_W-1:0] object_handle;
  logic [TIME_W-1:0]   time_value;

  modport source (output valid, output command, output object_handle,
                  output time_value, input ready);
  modport sink   (input valid, input command, input object_handle,
                  input time_value, output ready);
endinterface

interface tet_out_if;
  import tet_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [HANDLE_W-1:0] out_handle;
  logic [TIME_W-1:0]   fire_time;
  logic                dirty_flag;
  logic                overflow;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output found, output out_handle, output fire_time,
                  output dirty_flag, output overflow, output occupancy, input ready);
  modport sink   (input valid, input found, input out_handle, input fire_time,
                  input dirty_flag, input overflow, input occupancy, output ready);
endinterface

@@ design/tet_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tet_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event table controller
// Sequences one command at a time: execute, table scan, result, shift-down
// of the entries behind a removed one, and hand-off to the output register.
// ----------------------------------------------------------------------------
module tet_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tet_pkg::dp_stat_t  stat,
  output tet_pkg::ctrl_cmd_t cmd
);
  import tet_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_scan_cmd) begin
          state_nxt = stat.need_scan ? ST_SCAN : ST_RESOLVE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        state_nxt = stat.hit ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        if (stat.shift_all_issued && !stat.shift_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
      end
      ST_SHIFT: begin
        cmd.shift_rd  = !stat.shift_all_issued;
        cmd.shift_end = stat.shift_all_issued && !stat.shift_busy;
      end
      ST_DONE: begin
        cmd.ld_out = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/tet_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event table datapath
// Entry RAM, occupancy, current time and dirty flag, scan compare, shift-down
// pointer and the result output register.
// ----------------------------------------------------------------------------
module tet_dp #(
  parameter int unsigned CAPACITY    = tet_pkg::TET_CAPACITY,
  parameter int unsigned HANDLE_BITS = tet_pkg::TET_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tet_pkg::ctrl_cmd_t            cmd,
  output tet_pkg::dp_stat_t             stat,
  input  logic [tet_pkg::CMD_W-1:0]     in_command,
  input  logic [tet_pkg::HANDLE_W-1:0]  in_object_handle,
  input  logic [tet_pkg::TIME_W-1:0]    in_time_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [tet_pkg::HANDLE_W-1:0]  out_handle,
  output logic [tet_pkg::TIME_W-1:0]    out_fire_time,
  output logic                          out_dirty_flag,
  output logic                          out_overflow,
  output logic [tet_pkg::OCC_W-1:0]     out_occupancy
);
  import tet_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = HANDLE_BITS + TIME_W;

  // Latched command
  cmd_t                   cmd_r, cmd_nxt;
  logic [HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  logic [TIME_W-1:0]      tval_r, tval_nxt;

  // Table state
  logic [CW-1:0]          count_r, count_nxt;
  logic [TIME_W-1:0]      cur_time_r, cur_time_nxt;
  logic                   dirty_r, dirty_nxt;

  // Scan
  logic [CW-1:0]          scan_k_r, scan_k_nxt;
  logic                   scan_v_r, scan_v_nxt;
  logic [AW-1:0]          scan_idx_r, scan_idx_nxt;
  logic                   hit_r, hit_nxt;
  logic [AW-1:0]          best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]      min_due_r, min_due_nxt;
  logic [HANDLE_BITS-1:0] best_hdl_r, best_hdl_nxt;

  // Shift-down
  logic [CW-1:0]          sh_k_r, sh_k_nxt;
  logic                   sh_v_r, sh_v_nxt;
  logic [AW-1:0]          sh_idx_r, sh_idx_nxt;

  // Result and output register
  logic                   res_found_r, res_found_nxt;
  logic [HANDLE_W-1:0]    res_hdl_r, res_hdl_nxt;
  logic [TIME_W-1:0]      res_time_r, res_time_nxt;
  logic                   res_ovf_r, res_ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [HANDLE_W-1:0]    out_hdl_r, out_hdl_nxt;
  logic [TIME_W-1:0]      out_time_r, out_time_nxt;
  logic                   out_dirty_r, out_dirty_nxt;
  logic                   out_ovf_r, out_ovf_nxt;
  logic [OCC_W-1:0]       out_occ_r, out_occ_nxt;

  // RAM ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [TIME_W-1:0]      rd_due;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic                   take_better;

  tet_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_due = ram_rdata[TIME_W-1:0];
  assign rd_hdl = ram_rdata[EW-1:TIME_W];

  // After the first hit the compare is strict, so the earliest inserted
  // entry wins among equal due times.
  assign take_better = hit_r ? (rd_due < min_due_r) : (rd_due <= min_due_r);

  always_comb begin
    cmd_nxt       = cmd_r;
    hdl_nxt       = hdl_r;
    tval_nxt      = tval_r;
    count_nxt     = count_r;
    cur_time_nxt  = cur_time_r;
    dirty_nxt     = dirty_r;
    scan_k_nxt    = scan_k_r;
    scan_v_nxt    = 1'b0;
    scan_idx_nxt  = scan_idx_r;
    hit_nxt       = hit_r;
    best_idx_nxt  = best_idx_r;
    min_due_nxt   = min_due_r;
    best_hdl_nxt  = best_hdl_r;
    sh_k_nxt      = sh_k_r;
    sh_v_nxt      = 1'b0;
    sh_idx_nxt    = sh_idx_r;
    res_found_nxt = res_found_r;
    res_hdl_nxt   = res_hdl_r;
    res_time_nxt  = res_time_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_hdl_nxt   = out_hdl_r;
    out_time_nxt  = out_time_r;
    out_dirty_nxt = out_dirty_r;
    out_ovf_nxt   = out_ovf_r;
    out_occ_nxt   = out_occ_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = {hdl_r, tval_r};
    ram_raddr     = scan_k_r[AW-1:0];

    if (cmd.latch) begin
      cmd_nxt  = cmd_t'(in_command);
      hdl_nxt  = HANDLE_BITS'(in_object_handle);
      tval_nxt = in_time_value;
    end

    if (cmd.exec) begin
      scan_k_nxt    = '0;
      hit_nxt       = 1'b0;
      min_due_nxt   = cur_time_r;
      res_found_nxt = 1'b0;
      res_hdl_nxt   = '0;
      res_time_nxt  = '0;
      res_ovf_nxt   = 1'b0;
      case (cmd_r)
        CMD_ADD: begin
          if (count_r == CW'(CAPACITY)) begin
            res_ovf_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            if (tval_r <= cur_time_r) begin
              dirty_nxt = 1'b1;
            end
          end
        end
        CMD_SET_TIME:   cur_time_nxt = tval_r;
        CMD_MARK_DIRTY: dirty_nxt    = 1'b1;
        default: begin
        end
      endcase
    end

    if (cmd.scan_rd) begin
      ram_raddr    = scan_k_r[AW-1:0];
      scan_k_nxt   = scan_k_r + CW'(1);
      scan_v_nxt   = 1'b1;
      scan_idx_nxt = scan_k_r[AW-1:0];
    end

    // Read data of the previous scan beat is evaluated here.
    if (scan_v_r) begin
      if (cmd_r == CMD_TAKE) begin
        if (take_better) begin
          hit_nxt      = 1'b1;
          best_idx_nxt = scan_idx_r;
          min_due_nxt  = rd_due;
          best_hdl_nxt = rd_hdl;
        end
      end else if (rd_hdl == hdl_r) begin
        // Scanning upward, the last match is the most recently added one.
        hit_nxt      = 1'b1;
        best_idx_nxt = scan_idx_r;
      end
    end

    if (cmd.resolve) begin
      res_found_nxt = hit_r;
      sh_k_nxt      = CW'(best_idx_r) + CW'(1);
      if (cmd_r == CMD_TAKE) begin
        if (hit_r) begin
          res_hdl_nxt  = HANDLE_W'(best_hdl_r);
          res_time_nxt = min_due_r;
        end else begin
          dirty_nxt = 1'b0;
        end
      end
    end

    if (cmd.shift_rd) begin
      ram_raddr  = sh_k_r[AW-1:0];
      sh_k_nxt   = sh_k_r + CW'(1);
      sh_v_nxt   = 1'b1;
      sh_idx_nxt = sh_k_r[AW-1:0];
    end

    // Each entry read during the shift is written back one place lower.
    if (sh_v_r) begin
      ram_we    = 1'b1;
      ram_waddr = sh_idx_r - AW'(1);
      ram_wdata = ram_rdata;
    end

    if (cmd.shift_end) begin
      count_nxt = count_r - CW'(1);
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res_found_r;
      out_hdl_nxt   = res_hdl_r;
      out_time_nxt  = res_time_r;
      out_dirty_nxt = dirty_r;
      out_ovf_nxt   = res_ovf_r;
      out_occ_nxt   = OCC_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_time_r  <= '0;
      dirty_r     <= 1'b0;
      scan_v_r    <= 1'b0;
      sh_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cur_time_r  <= cur_time_nxt;
      dirty_r     <= dirty_nxt;
      scan_v_r    <= scan_v_nxt;
      sh_v_r      <= sh_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    hdl_r       <= hdl_nxt;
    tval_r      <= tval_nxt;
    scan_k_r    <= scan_k_nxt;
    scan_idx_r  <= scan_idx_nxt;
    hit_r       <= hit_nxt;
    best_idx_r  <= best_idx_nxt;
    min_due_r   <= min_due_nxt;
    best_hdl_r  <= best_hdl_nxt;
    sh_k_r      <= sh_k_nxt;
    sh_idx_r    <= sh_idx_nxt;
    res_found_r <= res_found_nxt;
    res_hdl_r   <= res_hdl_nxt;
    res_time_r  <= res_time_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_found_r <= out_found_nxt;
    out_hdl_r   <= out_hdl_nxt;
    out_time_r  <= out_time_nxt;
    out_dirty_r <= out_dirty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_occ_r   <= out_occ_nxt;
  end

  assign stat.is_scan_cmd      = (cmd_r == CMD_REMOVE) || (cmd_r == CMD_TAKE);
  assign stat.need_scan        = (count_r != '0);
  assign stat.scan_last        = ((scan_k_r + CW'(1)) == count_r);
  assign stat.hit              = hit_r;
  assign stat.shift_all_issued = (sh_k_r >= count_r);
  assign stat.shift_busy       = sh_v_r;
  assign stat.out_free         = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_handle     = out_hdl_r;
  assign out_fire_time  = out_time_r;
  assign out_dirty_flag = out_dirty_r;
  assign out_overflow   = out_ovf_r;
  assign out_occupancy  = out_occ_r;

endmodule

@@ design/timed_event_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event table
// Table of pending timed events with add, remove, take-next-due, set-time and
// mark-dirty commands, one result beat per command beat.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time. Add, set-time, mark-dirty and
// unused codes go from execution straight to a result in the output register.
// Remove and take-next read the N held entries through the single read port
// of the entry RAM, one per cycle, and when an entry leaves the table the
// entries behind it move down one place, one per cycle. A result waiting in
// the output register does not stop the next command beat from being
// accepted and started.
module timed_event_table #(
  parameter int unsigned CAPACITY    = tet_pkg::TET_CAPACITY,
  parameter int unsigned HANDLE_BITS = tet_pkg::TET_HANDLE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  tet_in_if.sink          in_chan,
  tet_out_if.source       out_chan
);
  import tet_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  dps;

  tet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (dps),
    .cmd      (ctl)
  );

  tet_dp #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (ctl),
    .stat             (dps),
    .in_command       (in_chan.command),
    .in_object_handle (in_chan.object_handle),
    .in_time_value    (in_chan.time_value),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_found        (out_chan.found),
    .out_handle       (out_chan.out_handle),
    .out_fire_time    (out_chan.fire_time),
    .out_dirty_flag   (out_chan.dirty_flag),
    .out_overflow     (out_chan.overflow),
    .out_occupancy    (out_chan.occupancy)
  );

endmodule
